// ----- design/ttgs_pkg.sv -----
// Shared types and constants for the text terminal cursor controller.
`timescale 1ns / 1ps
`default_nettype none

package ttgs_pkg;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_PEN     = 2'd2;

    localparam logic [8:0] COLUMNS_RESET = 9'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;
    localparam logic [7:0] PEN_RESET     = 8'd0;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // Steps of the restoring reduction of the top row after a row count change.
    localparam logic [2:0] NORM_STEPS = 3'd6;

    typedef struct packed {
        logic [7:0] col;
        logic [5:0] row;
        logic [5:0] top;
    } cursor_t;

    typedef struct packed {
        logic       write_valid;
        logic [5:0] write_row;
        logic [7:0] write_col;
        logic [6:0] write_glyph;
        logic [7:0] write_attribute;
        logic       clear_valid;
        logic [5:0] clear_row;
        logic       escape_seen;
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
        logic [5:0] top_row;
    } result_t;

endpackage

`default_nettype wire

// ----- design/ttgs_core.sv -----
// Combinational cursor update for one byte of the terminal stream.
`timescale 1ns / 1ps
`default_nettype none

module ttgs_core
    import ttgs_pkg::*;
#(
    parameter int TAB_STOP = 8
)
(
    input  logic [7:0] byte_in,
    input  cursor_t    cur,
    input  logic [8:0] ncols,
    input  logic [6:0] nrows,
    input  logic [7:0] pen,
    output cursor_t    nxt,
    output result_t    res
);

    logic [8:0] tab_tab [256];
    logic [7:0] last_col;
    logic [5:0] last_row;
    logic [7:0] col_c;
    logic [5:0] row_c;
    logic [6:0] row_sum;
    logic [5:0] phys_row;
    logic       row_last;
    logic [5:0] top_inc;
    logic [8:0] tab_next;
    logic [7:0] tab_col;
    logic       col_wrap;
    logic       do_feed;

    // Next tab stop for every column, worked out at elaboration.
    for (genvar i = 0; i < 256; i++) begin : g_tab
        assign tab_tab[i] = 9'((i / TAB_STOP + 1) * TAB_STOP);
    end

    assign last_col = 8'(ncols - 9'd1);
    assign last_row = 6'(nrows - 7'd1);
    assign col_c    = (cur.col > last_col) ? last_col : cur.col;
    assign row_c    = (cur.row > last_row) ? last_row : cur.row;
    assign row_sum  = {1'b0, cur.top} + {1'b0, row_c};
    assign phys_row = (row_sum >= nrows) ? 6'(row_sum - nrows) : row_sum[5:0];
    assign row_last = ({1'b0, row_c} + 7'd1) >= nrows;
    assign top_inc  = (({1'b0, cur.top} + 7'd1) == nrows) ? 6'd0 : 6'(cur.top + 6'd1);
    assign tab_next = tab_tab[col_c];
    assign tab_col  = (tab_next < {1'b0, last_col}) ? tab_next[7:0] : last_col;
    assign col_wrap = ({1'b0, col_c} + 9'd1) >= ncols;

    always_comb
    begin
        nxt     = '{col: col_c, row: row_c, top: cur.top};
        res     = '0;
        do_feed = 1'b0;
        priority if (byte_in == CH_ESC)
        begin
            res.escape_seen = 1'b1;
        end
        else if (byte_in == CH_CR)
        begin
            nxt.col = 8'd0;
        end
        else if (byte_in == CH_LF || byte_in == CH_VT || byte_in == CH_FF)
        begin
            do_feed = 1'b1;
        end
        else if (byte_in == CH_BS)
        begin
            if (col_c != 8'd0)
            begin
                nxt.col = col_c - 8'd1;
            end
        end
        else if (byte_in == CH_TAB)
        begin
            nxt.col = tab_col;
        end
        else if (byte_in == CH_BEL || byte_in < CH_SPACE)
        begin
            nxt.col = col_c;
        end
        else if (byte_in < CH_DEL)
        begin
            res.write_valid     = 1'b1;
            res.write_row       = phys_row;
            res.write_col       = col_c;
            res.write_glyph     = byte_in[6:0];
            res.write_attribute = pen;
            if (col_wrap)
            begin
                nxt.col = 8'd0;
                do_feed = 1'b1;
            end
            else
            begin
                nxt.col = col_c + 8'd1;
            end
        end
        else
        begin
            nxt.col = col_c;
        end

        if (do_feed)
        begin
            if (!row_last)
            begin
                nxt.row = row_c + 6'd1;
            end
            else
            begin
                // The old top line becomes the new, blank bottom line.
                res.clear_valid = 1'b1;
                res.clear_row   = cur.top;
                nxt.top         = top_inc;
            end
        end

        res.cursor_col = nxt.col;
        res.cursor_row = nxt.row;
        res.top_row    = nxt.top;
    end

endmodule

`default_nettype wire

// ----- design/text_terminal_ground_state.sv -----
// Top level of the text terminal cursor controller.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per item and returns one result item per byte, at a sustained
// rate of one item per clock cycle while results are taken and no top-row
// reduction runs. An item is captured in an input register; its cursor update
// is computed combinationally and held in a result register when the output
// advances. While a finished result waits to be taken, one more byte is
// accepted into the input register, and in_ready then stays low until the
// result is taken. A CFG_ROWS write starts a reduction of the circular top-row
// pointer by the new row count, one quotient bit per cycle, with in_ready low.
module text_terminal_ground_state
    import ttgs_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 64,
    parameter int TAB_STOP = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_valid,
    output logic [5:0] write_row,
    output logic [7:0] write_col,
    output logic [6:0] write_glyph,
    output logic [7:0] write_attribute,
    output logic       clear_valid,
    output logic [5:0] clear_row,
    output logic       escape_seen,
    output logic [7:0] cursor_col_out,
    output logic [5:0] cursor_row_out,
    output logic [5:0] top_row_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    logic [8:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic [7:0]  pen_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    cursor_t     cursor_reg;
    logic [5:0]  top_norm_reg;
    logic [2:0]  norm_cnt_reg;
    logic [8:0]  ncols;
    logic [6:0]  nrows;
    cursor_t     cursor_cur;
    cursor_t     cursor_next;
    result_t     result_next;
    logic        advance;
    logic        fire;
    logic        norm_busy;
    logic [2:0]  norm_shift;
    logic [11:0] norm_div;
    logic [11:0] norm_top;

    assign ncols = (columns_reg == 9'd0) ? 9'd1 :
                   (columns_reg > 9'(MAX_COLS)) ? 9'(MAX_COLS) : columns_reg;
    assign nrows = (rows_reg == 7'd0) ? 7'd1 :
                   (rows_reg > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_reg;

    assign cfg_ready  = 1'b1;
    assign norm_busy  = norm_cnt_reg != 3'd0;
    assign norm_shift = norm_cnt_reg - 3'd1;
    assign norm_div   = 12'(nrows) << norm_shift;
    assign norm_top   = 12'(top_norm_reg);
    assign advance    = !out_valid_reg || out_ready;
    assign fire       = in_valid_reg && advance;
    assign in_ready   = !norm_busy && (!in_valid_reg || advance);

    // The top row left by the last byte is reduced by the current row count.
    assign cursor_cur = '{col: cursor_reg.col, row: cursor_reg.row, top: top_norm_reg};

    ttgs_core #(
        .TAB_STOP(TAB_STOP)
    ) u_core (
        .byte_in(byte_reg),
        .cur    (cursor_cur),
        .ncols  (ncols),
        .nrows  (nrows),
        .pen    (pen_reg),
        .nxt    (cursor_next),
        .res    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg  <= COLUMNS_RESET;
            rows_reg     <= ROWS_RESET;
            pen_reg      <= PEN_RESET;
            norm_cnt_reg <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:
                begin
                    columns_reg <= cfg_data;
                end
                CFG_ROWS:
                begin
                    rows_reg     <= cfg_data[6:0];
                    norm_cnt_reg <= NORM_STEPS;
                end
                CFG_PEN:
                begin
                    pen_reg <= cfg_data[7:0];
                end
                default:
                begin
                    pen_reg <= pen_reg;
                end
            endcase
        end
        else if (norm_busy)
        begin
            norm_cnt_reg <= norm_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            top_norm_reg <= 6'd0;
        end
        else if (fire)
        begin
            cursor_reg   <= cursor_next;
            top_norm_reg <= cursor_next.top;
        end
        else if (cfg_valid && cfg_ready && cfg_index == CFG_ROWS)
        begin
            top_norm_reg <= cursor_reg.top;
        end
        else if (norm_busy && norm_top >= norm_div)
        begin
            top_norm_reg <= 6'(norm_top - norm_div);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign write_valid     = result_reg.write_valid;
    assign write_row       = result_reg.write_row;
    assign write_col       = result_reg.write_col;
    assign write_glyph     = result_reg.write_glyph;
    assign write_attribute = result_reg.write_attribute;
    assign clear_valid     = result_reg.clear_valid;
    assign clear_row       = result_reg.clear_row;
    assign escape_seen     = result_reg.escape_seen;
    assign cursor_col_out  = result_reg.cursor_col;
    assign cursor_row_out  = result_reg.cursor_row;
    assign top_row_out     = result_reg.top_row;

endmodule

`default_nettype wire

// ----- design/ttgs_checker.sv -----
// Port-level checks for the text terminal cursor controller and their binding.
`timescale 1ns / 1ps
`default_nettype none

module ttgs_checker
(
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire       write_valid,
    input wire [5:0] write_row,
    input wire [7:0] write_col,
    input wire [6:0] write_glyph,
    input wire [7:0] write_attribute,
    input wire       clear_valid,
    input wire [5:0] clear_row,
    input wire       escape_seen,
    input wire [7:0] cursor_col_out,
    input wire [5:0] cursor_row_out,
    input wire [5:0] top_row_out
);

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_row) && $stable(write_col)
            && $stable(cursor_col_out) && $stable(cursor_row_out) && $stable(top_row_out))
        else $error("result item changed while stalled");

    // Without a cell write, the write fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> write_row == 6'd0 && write_col == 8'd0
            && write_glyph == 7'd0 && write_attribute == 8'd0)
        else $error("write fields set without a cell write");

    // Without a scroll, the clear row reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !clear_valid |-> clear_row == 6'd0)
        else $error("clear row set without a scroll");

    // Only printable codes reach the cell memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> write_glyph >= 7'h20 && write_glyph != 7'h7f)
        else $error("non-printable glyph written");

    // An escape byte neither writes nor scrolls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && escape_seen |-> !write_valid && !clear_valid)
        else $error("escape byte caused a write or a scroll");

endmodule

bind text_terminal_ground_state ttgs_checker u_ttgs_checker (.*);

`default_nettype wire
